// ===== design/mil_pkg.sv =====
// ----------------------------------------------------------------------------
// mil_pkg: shared definitions for the MRU identifier list
// Holds the list depth, field widths, opcodes and the command bundle that
// the controller sends to the row of list cells.
// ----------------------------------------------------------------------------
package mil_pkg;

    // List depth and the widths that follow from it.
    localparam int DEPTH = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fixed field widths of the transactions.
    localparam int ID_W     = 63;
    localparam int OP_W     = 2;
    localparam int PAGE_W   = 6;
    localparam int PSIZE_W  = 6;
    localparam int LCOUNT_W = 6;
    localparam int START_W  = PAGE_W + PSIZE_W;
    localparam int STOP_W   = START_W + 1;

    // Page size after reset.
    localparam logic [PSIZE_W-1:0] PAGE_SIZE_RST = PSIZE_W'(8);

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } t_opcode;

    // Command broadcast to every cell of the list.
    typedef struct packed {
        logic            apply_add;
        logic            apply_remove;
        logic [ID_W-1:0] id;
    } t_cell_cmd;

endpackage

// ===== design/mru_id_list_core.sv =====
// ----------------------------------------------------------------------------
// mru_id_list_core: most-recently-used identifier list, newest first
// An update runs through the execute state to its one result; a page read runs
// through the execute and page states, then gives one entry per cycle while
// the receiver does not stall. It accepts only when idle, so it takes no new
// transaction before the last is done. Receiver stalls hold the controller.
// Reset clears list count, controller and output valid; page size resets to 8.
// ----------------------------------------------------------------------------
module mru_id_list_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [mil_pkg::PSIZE_W-1:0]     i_cfg_data,
    // Input channel.
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [mil_pkg::OP_W-1:0]        i_opcode,
    input  logic [mil_pkg::ID_W-1:0]        i_product_number,
    input  logic [mil_pkg::PAGE_W-1:0]      i_page_index,
    // Output channel.
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [mil_pkg::ID_W-1:0]        o_entry_value,
    output logic                            o_entry_valid,
    output logic                            o_changed,
    output logic                            o_has_next_page,
    output logic [mil_pkg::LCOUNT_W-1:0]    o_list_count,
    output logic                            o_last
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_PAGE = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    logic [mil_pkg::PSIZE_W-1:0]     r_page_size;
    logic [mil_pkg::CNT_W-1:0]       r_count, n_count;
    mil_pkg::t_opcode                r_op;
    logic [mil_pkg::ID_W-1:0]        r_id;
    logic [mil_pkg::PAGE_W-1:0]      r_page;
    logic [mil_pkg::CNT_W-1:0]       r_idx, n_idx;
    logic [mil_pkg::CNT_W-1:0]       r_stop, n_stop;
    logic                            r_nxt, n_nxt;
    logic                            r_empty, n_empty;

    logic                            r_out_valid, n_out_valid;
    logic [mil_pkg::ID_W-1:0]        r_entry_value, n_entry_value;
    logic                            r_entry_valid, n_entry_valid;
    logic                            r_changed, n_changed;
    logic                            r_has_next, n_has_next;
    logic [mil_pkg::CNT_W-1:0]       r_list_count, n_list_count;
    logic                            r_last, n_last;

    logic                            w_accept;
    logic                            w_slot_free;
    logic                            w_front_hit;
    logic                            w_found;
    logic [mil_pkg::ID_W-1:0]        w_read_value;
    mil_pkg::t_cell_cmd              w_cmd;
    logic [mil_pkg::START_W-1:0]     w_start;
    logic [mil_pkg::STOP_W-1:0]      w_stop;
    logic [mil_pkg::STOP_W-1:0]      w_stop_c;
    logic [mil_pkg::STOP_W-1:0]      w_count_x;
    logic                            w_upd_fire;
    logic                            w_page_last;

    // Handshakes.
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_upd_fire  = (r_state == S_EXEC) && (r_op != mil_pkg::OP_READ) && w_slot_free;

    // Command to the cell row; an add of the front entry changes nothing.
    always_comb begin
        w_cmd.id           = r_id;
        w_cmd.apply_add    = w_upd_fire && (r_op == mil_pkg::OP_ADD) && !w_front_hit;
        w_cmd.apply_remove = w_upd_fire && (r_op == mil_pkg::OP_REMOVE) && w_found;
    end

    mil_cell_chain u_chain (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .i_count      (r_count),
        .i_read_idx   (r_idx[mil_pkg::IDX_W-1:0]),
        .o_front_hit  (w_front_hit),
        .o_found      (w_found),
        .o_read_value (w_read_value)
    );

    // Page bounds for a read transaction.
    assign w_start   = mil_pkg::START_W'(r_page) * mil_pkg::START_W'(r_page_size);
    assign w_stop    = mil_pkg::STOP_W'(w_start) + mil_pkg::STOP_W'(r_page_size);
    assign w_count_x = mil_pkg::STOP_W'(r_count);
    assign w_stop_c  = (w_stop > w_count_x) ? w_count_x : w_stop;
    assign w_page_last = (r_idx + mil_pkg::CNT_W'(1)) == r_stop;

    // Controller and output register.
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_stop        = r_stop;
        n_nxt         = r_nxt;
        n_empty       = r_empty;
        n_out_valid   = r_out_valid && i_out_stall;
        n_entry_value = r_entry_value;
        n_entry_valid = r_entry_valid;
        n_changed     = r_changed;
        n_has_next    = r_has_next;
        n_list_count  = r_list_count;
        n_last        = r_last;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_op == mil_pkg::OP_READ) begin
                    n_idx   = mil_pkg::CNT_W'(w_start);
                    n_stop  = mil_pkg::CNT_W'(w_stop_c);
                    n_nxt   = w_stop < w_count_x;
                    n_empty = mil_pkg::STOP_W'(w_start) >= w_stop_c;
                    n_state = S_PAGE;
                end else if (w_slot_free) begin
                    n_changed = 1'b0;
                    case (r_op)
                        mil_pkg::OP_ADD: begin
                            if (!w_front_hit) begin
                                n_changed = 1'b1;
                                if (!w_found && (r_count != mil_pkg::CNT_W'(mil_pkg::DEPTH))) begin
                                    n_count = r_count + mil_pkg::CNT_W'(1);
                                end
                            end
                        end
                        mil_pkg::OP_REMOVE: begin
                            if (w_found) begin
                                n_changed = 1'b1;
                                n_count   = r_count - mil_pkg::CNT_W'(1);
                            end
                        end
                        default: begin
                            n_changed = (r_count != '0);
                            n_count   = '0;
                        end
                    endcase
                    n_out_valid   = 1'b1;
                    n_entry_value = '0;
                    n_entry_valid = 1'b0;
                    n_has_next    = 1'b0;
                    n_list_count  = n_count;
                    n_last        = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_PAGE: begin
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_changed    = 1'b0;
                    n_has_next   = r_nxt;
                    n_list_count = r_count;
                    if (r_empty) begin
                        n_entry_value = '0;
                        n_entry_valid = 1'b0;
                        n_last        = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        n_entry_value = w_read_value;
                        n_entry_valid = 1'b1;
                        n_last        = w_page_last;
                        n_idx         = r_idx + mil_pkg::CNT_W'(1);
                        if (w_page_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_page_size <= mil_pkg::PAGE_SIZE_RST;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_page_size <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= mil_pkg::t_opcode'(i_opcode);
            r_id   <= i_product_number;
            r_page <= i_page_index;
        end
        r_idx         <= n_idx;
        r_stop        <= n_stop;
        r_nxt         <= n_nxt;
        r_empty       <= n_empty;
        r_entry_value <= n_entry_value;
        r_entry_valid <= n_entry_valid;
        r_changed     <= n_changed;
        r_has_next    <= n_has_next;
        r_list_count  <= n_list_count;
        r_last        <= n_last;
    end

    // Output ports.
    assign o_out_valid     = r_out_valid;
    assign o_entry_value   = r_entry_value;
    assign o_entry_valid   = r_entry_valid;
    assign o_changed       = r_changed;
    assign o_has_next_page = r_has_next;
    assign o_list_count    = mil_pkg::LCOUNT_W'(r_list_count);
    assign o_last          = r_last;

    // The list never holds more entries than it has cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mil_pkg::CNT_W'(mil_pkg::DEPTH))
        else $error("list count exceeds depth");

    // An accepted transaction always moves to the execute step.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted transaction did not reach execute");

    // An update leaves the controller idle with a result pending.
    a_update_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_upd_fire |=> (r_state == S_IDLE) && r_out_valid && r_last)
        else $error("update did not complete as expected");

    // A nonempty page walk stays inside the list.
    a_page_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAGE) && !r_empty |-> (r_idx < r_stop) && (r_stop <= r_count))
        else $error("page position outside the list");

    // An add that alters the list leaves it nonempty.
    a_add_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.apply_add |=> (r_count != '0))
        else $error("list empty after add");

endmodule

// ===== design/mil_cell.sv =====
// ----------------------------------------------------------------------------
// mil_cell: one position of the MRU list
// Holds one identifier, compares it against the command identifier, and on
// an update takes the value of its left or right neighbor.
// ----------------------------------------------------------------------------
module mil_cell (
    input  logic                         i_clk,
    input  mil_pkg::t_cell_cmd           i_cmd,
    input  logic                         i_occupied,
    input  logic [mil_pkg::ID_W-1:0]     i_left_value,
    input  logic [mil_pkg::ID_W-1:0]     i_right_value,
    input  logic                         i_found_in,
    output logic                         o_found_out,
    output logic                         o_match,
    output logic [mil_pkg::ID_W-1:0]     o_value
);

    logic [mil_pkg::ID_W-1:0] r_value;
    logic [mil_pkg::ID_W-1:0] n_value;

    // A match only counts for a position that lies inside the list.
    assign o_match     = i_occupied && (r_value == i_cmd.id);
    assign o_found_out = i_found_in || o_match;
    assign o_value     = r_value;

    // Add shifts right up to and including the earlier copy; remove closes
    // the gap from the match onward.
    always_comb begin
        n_value = r_value;
        if (i_cmd.apply_add && !i_found_in) begin
            n_value = i_left_value;
        end else if (i_cmd.apply_remove && o_found_out) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// ===== design/mil_cell_chain.sv =====
// ----------------------------------------------------------------------------
// mil_cell_chain: the row of list cells
// Links the cells to their neighbors, ripples the match flag along the row
// and selects one entry for page reads.
// ----------------------------------------------------------------------------
module mil_cell_chain (
    input  logic                          i_clk,
    input  mil_pkg::t_cell_cmd            i_cmd,
    input  logic [mil_pkg::CNT_W-1:0]     i_count,
    input  logic [mil_pkg::IDX_W-1:0]     i_read_idx,
    output logic                          o_front_hit,
    output logic                          o_found,
    output logic [mil_pkg::ID_W-1:0]      o_read_value
);

    logic [mil_pkg::ID_W-1:0] w_value [mil_pkg::DEPTH];
    logic [mil_pkg::DEPTH:0]  w_found;
    logic [mil_pkg::DEPTH-1:0] w_match;

    assign w_found[0] = 1'b0;

    // One cell per list position; the front cell takes the new identifier.
    for (genvar gi = 0; gi < mil_pkg::DEPTH; gi++) begin : g_cell
        logic [mil_pkg::ID_W-1:0] w_left;
        logic [mil_pkg::ID_W-1:0] w_right;
        logic                     w_occupied;

        if (gi == 0) begin : g_front
            assign w_left = i_cmd.id;
        end else begin : g_mid_l
            assign w_left = w_value[gi-1];
        end

        if (gi == mil_pkg::DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_value[gi+1];
        end

        assign w_occupied = mil_pkg::CNT_W'(gi) < i_count;

        mil_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (i_cmd),
            .i_occupied    (w_occupied),
            .i_left_value  (w_left),
            .i_right_value (w_right),
            .i_found_in    (w_found[gi]),
            .o_found_out   (w_found[gi+1]),
            .o_match       (w_match[gi]),
            .o_value       (w_value[gi])
        );
    end

    // Summary flags for the controller.
    assign o_front_hit  = w_match[0];
    assign o_found      = w_found[mil_pkg::DEPTH];

    // Entry selected for the current page position.
    assign o_read_value = w_value[i_read_idx];

endmodule
